/* rtl/core/sle_pkg.sv */
package sle_pkg;

  // Default line store depth
  localparam int BUFFER_SIZE_DEF = 64;

  // Width of the line_length result field
  localparam int LEN_W = 6;

  // Width of the configuration register index
  localparam int CFG_IDX_W = 2;

  // Character codes
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_SOH  = 8'h01;
  localparam logic [7:0] CH_ENQ  = 8'h05;
  localparam logic [7:0] CH_ACK  = 8'h06;
  localparam logic [7:0] CH_BEL  = 8'h07;
  localparam logic [7:0] CH_BS   = 8'h08;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SO   = 8'h0E;
  localparam logic [7:0] CH_XON  = 8'h11;
  localparam logic [7:0] CH_XOFF = 8'h13;
  localparam logic [7:0] CH_NAK  = 8'h15;
  localparam logic [7:0] CH_US   = 8'h1F;
  localparam logic [7:0] CH_DEL  = 8'h7F;

  // Event codes reported with the status item
  typedef enum logic [2:0] {
    EV_NONE,
    EV_ENQ,
    EV_BEL,
    EV_ACK,
    EV_NAK,
    EV_XON,
    EV_XOFF
  } event_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RAW,
    REG_ECHO,
    REG_ERASE,
    REG_STRIP
  } cfg_reg_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CRCHK,
    ST_STREAM
  } state_t;

  // Classification of one received byte
  typedef struct packed {
    logic   is_bs;     // edit backspace
    logic   is_lf;     // line terminator
    logic   is_store;  // byte goes into the line store
    event_t ev;
  } dec_t;

endpackage

/* rtl/core/sle_ram.sv */
module sle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/sle_decode.sv */
module sle_decode (
  input  logic          raw_mode,
  input  logic [7:0]    rx_byte,
  output sle_pkg::dec_t dec
);

  import sle_pkg::*;

  logic ctrl;

  // Control bytes that are dropped outside raw mode
  assign ctrl = rx_byte inside {[CH_SOH:CH_BEL], [CH_SO:CH_US], CH_DEL};

  always_comb begin
    case (rx_byte)
      CH_ENQ:  dec.ev = EV_ENQ;
      CH_BEL:  dec.ev = EV_BEL;
      CH_ACK:  dec.ev = EV_ACK;
      CH_NAK:  dec.ev = EV_NAK;
      CH_XON:  dec.ev = EV_XON;
      CH_XOFF: dec.ev = EV_XOFF;
      default: dec.ev = EV_NONE;
    endcase
    dec.is_bs    = (rx_byte == CH_BS) && !raw_mode;
    dec.is_lf    = (rx_byte == CH_LF);
    dec.is_store = (rx_byte != CH_NUL) && !dec.is_bs && !dec.is_lf && (raw_mode || !ctrl);
  end

endmodule

/* rtl/core/serial_line_editor.sv */
// Serial line editor. Each received byte item gives one status item (echo, erase
// request, event code, line completion, overflow); a newline is followed by one
// line-byte item per character of the completed line. A byte is taken into an
// input register, so one new item can be accepted while a result waits. A
// non-newline byte's status item is loaded from the input register. A newline's
// status item follows a line store write and a registered read for the CR check;
// then the line streams from the line store at one byte per cycle while out_ready
// is high. The line store needs no clearing pass after reset.
module serial_line_editor #(
  parameter int BUFFER_SIZE = sle_pkg::BUFFER_SIZE_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         cfg_wr_en,
  input  logic [sle_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic                         cfg_wdata,
  // input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   rx_byte,
  // output channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         item_kind,
  output logic                         echo_valid,
  output logic [7:0]                   echo_char,
  output logic                         erase_request,
  output logic [2:0]                   event_code,
  output logic                         line_done,
  output logic [sle_pkg::LEN_W-1:0]    line_length,
  output logic                         overflow,
  output logic [7:0]                   line_char,
  output logic                         last_of_run
);

  import sle_pkg::*;

  localparam int AW = $clog2(BUFFER_SIZE);
  localparam logic [AW-1:0] FILL_MAX = AW'(BUFFER_SIZE - 2);

  // Configuration
  logic raw_mode, echo_enable, erase_on_backspace, strip_line_ending;

  // Control state
  state_t        state, state_next;
  logic          in_full, in_full_next;
  logic [7:0]    in_byte;
  logic [AW-1:0] fill_count, fill_count_next;
  logic [AW-1:0] line_len, line_len_next;
  logic [AW-1:0] idx, idx_next;
  logic          out_valid_next;

  // Output register next values
  logic                item_kind_next, echo_valid_next, erase_request_next;
  logic [7:0]          echo_char_next, line_char_next;
  logic [2:0]          event_code_next;
  logic                line_done_next, overflow_next, last_of_run_next, load_out;
  logic [LEN_W-1:0]    line_length_next;

  // Line store port
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  dec_t          dec;
  logic          out_free;
  logic [AW-1:0] len_calc;

  sle_decode u_decode (
    .raw_mode (raw_mode),
    .rx_byte  (in_byte),
    .dec      (dec)
  );

  sle_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_SIZE),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready = !in_full;
  assign out_free = !out_valid || out_ready;

  // Completed line length from the registered CR check read
  always_comb begin
    if (strip_line_ending) begin
      if ((fill_count != '0) && (ram_rdata == CH_CR)) begin
        len_calc = fill_count - 1'b1;
      end else begin
        len_calc = fill_count;
      end
    end else begin
      len_calc = fill_count + 1'b1;
    end
  end

  // Next state, store access and result items
  always_comb begin
    state_next         = state;
    in_full_next       = in_full;
    fill_count_next    = fill_count;
    line_len_next      = line_len;
    idx_next           = idx;
    out_valid_next     = out_valid && !out_ready;
    load_out           = 1'b0;
    item_kind_next     = 1'b0;
    echo_valid_next    = 1'b0;
    echo_char_next     = '0;
    erase_request_next = 1'b0;
    event_code_next    = EV_NONE;
    line_done_next     = 1'b0;
    line_length_next   = '0;
    overflow_next      = 1'b0;
    line_char_next     = '0;
    last_of_run_next   = 1'b0;
    ram_we             = 1'b0;
    ram_waddr          = fill_count;
    ram_wdata          = in_byte;
    ram_raddr          = (fill_count == '0) ? '0 : fill_count - 1'b1;

    if (in_valid && in_ready) begin
      in_full_next = 1'b1;
    end

    case (state)
      ST_IDLE: begin
        if (in_full && out_free) begin
          in_full_next = 1'b0;
          if (dec.is_lf) begin
            // store LF, read back the previous byte for the CR check
            ram_we     = 1'b1;
            ram_wdata  = CH_LF;
            state_next = ST_CRCHK;
          end else begin
            load_out           = 1'b1;
            echo_valid_next    = echo_enable && (dec.is_bs || dec.is_store);
            echo_char_next     = echo_valid_next ? in_byte : '0;
            erase_request_next = dec.is_bs && echo_enable && erase_on_backspace;
            event_code_next    = dec.ev;
            last_of_run_next   = 1'b1;
            if (dec.is_bs) begin
              fill_count_next = (fill_count == '0) ? '0 : fill_count - 1'b1;
            end else if (dec.is_store) begin
              ram_we = 1'b1;
              if (fill_count == FILL_MAX) begin
                fill_count_next = '0;
                overflow_next   = 1'b1;
              end else begin
                fill_count_next = fill_count + 1'b1;
              end
            end
          end
        end
      end
      ST_CRCHK: begin
        // status item of the completed line; start reading the line
        load_out         = 1'b1;
        echo_valid_next  = echo_enable;
        echo_char_next   = echo_enable ? CH_LF : '0;
        event_code_next  = dec.ev;
        line_done_next   = 1'b1;
        line_length_next = LEN_W'(len_calc);
        last_of_run_next = (len_calc == '0);
        line_len_next    = len_calc;
        fill_count_next  = '0;
        idx_next         = '0;
        ram_raddr        = '0;
        state_next       = (len_calc == '0) ? ST_IDLE : ST_STREAM;
      end
      ST_STREAM: begin
        // read data always holds store[idx]
        ram_raddr = idx;
        if (out_free) begin
          load_out         = 1'b1;
          item_kind_next   = 1'b1;
          line_char_next   = ram_rdata;
          last_of_run_next = (idx == line_len - 1'b1);
          idx_next         = idx + 1'b1;
          ram_raddr        = idx + 1'b1;
          if (last_of_run_next) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (load_out) begin
      out_valid_next = 1'b1;
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full    <= 1'b0;
      out_valid  <= 1'b0;
      fill_count <= '0;
      line_len   <= '0;
      idx        <= '0;
    end else begin
      in_full    <= in_full_next;
      out_valid  <= out_valid_next;
      fill_count <= fill_count_next;
      line_len   <= line_len_next;
      idx        <= idx_next;
    end
  end

  // Input item register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= rx_byte;
    end
  end

  // Result item register
  always_ff @(posedge clk) begin
    if (load_out) begin
      item_kind     <= item_kind_next;
      echo_valid    <= echo_valid_next;
      echo_char     <= echo_char_next;
      erase_request <= erase_request_next;
      event_code    <= event_code_next;
      line_done     <= line_done_next;
      line_length   <= line_length_next;
      overflow      <= overflow_next;
      line_char     <= line_char_next;
      last_of_run   <= last_of_run_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_mode           <= 1'b0;
      echo_enable        <= 1'b1;
      erase_on_backspace <= 1'b0;
      strip_line_ending  <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_RAW:   raw_mode           <= cfg_wdata;
        REG_ECHO:  echo_enable        <= cfg_wdata;
        REG_ERASE: erase_on_backspace <= cfg_wdata;
        REG_STRIP: strip_line_ending  <= cfg_wdata;
        default:   ;
      endcase
    end
  end

`ifndef SYNTHESIS
  // fill count never goes beyond the overflow point
  assert property (@(posedge clk) disable iff (rst) fill_count <= FILL_MAX)
    else $error("fill count beyond overflow point");

  // streaming only runs for a non-empty line
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_STREAM) |-> (line_len != '0))
    else $error("streaming an empty line");

  // an accepted item occupies the input register until processed
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input register overwritten");

  // a new result is loaded only into a free output register
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(line_char) && $stable(item_kind)))
    else $error("stalled result changed");
`endif

endmodule
